>>> rtl/core/bitmap_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(label, clk, rst_n, prop, msg)
`define BPA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants and types of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;
	localparam int unsigned MaxPagesDef  = 65536;
	localparam int unsigned PageBytesDef = 4096;
	localparam int unsigned AddrW = 48;
	localparam int unsigned CntW  = 17;
	localparam int unsigned WordW = 64;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_MEM    = 3'd1,
		ST_FREE_ZERO = 3'd2,
		ST_UNALIGNED = 3'd3,
		ST_BEYOND    = 3'd4,
		ST_DBL_FREE  = 3'd5,
		ST_CLIPPED   = 3'd6
	} status_t;

	// lowest set bit index of a 64-bit word
	function automatic logic [5:0] first_set(input logic [WordW-1:0] w);
		logic [5:0] r;
		r = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (w[i]) r = 6'(i);
		end
		return r;
	endfunction
endpackage

>>> rtl/core/bpa_map_ram.sv
// ----------------------------------------------------------------------------
// bpa_map_ram
// bitmap word store, one write and one registered read port
// ----------------------------------------------------------------------------
module bpa_map_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bpa_pkg::WordW-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [bpa_pkg::WordW-1:0] rdata
);
	import bpa_pkg::*;

	logic [WordW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/bitmap_page_allocator.sv
// sequence: an accepted beat goes through S_PREP, then S_RD and S_MOD (S_FREE for a free)
//   per word, then S_OUT; a rejected free or an empty range goes from S_PREP to S_OUT
// throughput: one beat at a time; the bitmap port is read then written per word
// a scan or range sweep reads each 64-page word in S_RD, then modifies/writes it in S_MOD
// reset: after arst_n the bitmap is swept to all ones, one word a cycle
//   (MAX_PAGES/64 words rounded up, 1024 by default) while s_tready stays low
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// next-fit page frame allocator over a used/free bitmap held in one memory
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_defines.svh"
module bitmap_page_allocator #(
	parameter int unsigned MAX_PAGES  = bpa_pkg::MaxPagesDef,
	parameter int unsigned PAGE_BYTES = bpa_pkg::PageBytesDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bpa_pkg::CntW-1:0]   cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// address[47:0], length[95:48]
	input  logic [95:0]                s_tdata,
	// operation[1:0]
	input  logic [1:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// page_address[47:0], status[50:48], zero fill to 56 bits
	output logic [55:0]                m_tdata
);
	import bpa_pkg::*;

	localparam int unsigned Words = (MAX_PAGES + WordW - 1) / WordW;
	localparam int unsigned WA    = (Words > 1) ? $clog2(Words) : 1;
	localparam int unsigned PW    = $clog2(MAX_PAGES) + 1;   // page numbers up to MAX_PAGES
	localparam int unsigned PS    = $clog2(PAGE_BYTES);      // byte to page shift
	localparam int unsigned XW    = AddrW + 2;               // range end plus round-up carry
	localparam int unsigned WAW   = WA + 1;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_PREP  = 8'b0000_0100,
		S_RD    = 8'b0000_1000,
		S_MOD   = 8'b0001_0000,
		S_FREE  = 8'b0010_0000,
		S_DONE  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [CntW-1:0]    total_q;
	logic [CntW-1:0]    hint_q;
	logic [1:0]         op_q;
	logic [AddrW-1:0]   addr_q;
	logic [AddrW-1:0]   len_q;
	logic [PW-1:0]      lo_q, hi_q;      // current page span [lo, hi)
	logic               wrap_q;          // allocate is in its second scan
	logic [PW-1:0]      wrap_end_q;
	logic [WAW-1:0]     clr_q;
	logic [AddrW-1:0]   res_addr_q;
	status_t            res_st_q;

	// memory port
	logic               we;
	logic [WA-1:0]      waddr, raddr;
	logic [WordW-1:0]   wdata, rdata;

	bpa_map_ram #(.DEPTH(Words), .AW(WA)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// effective page count
	logic [PW-1:0] count;
	always_comb begin
		if (32'(total_q) > MAX_PAGES) count = PW'(MAX_PAGES);
		else                          count = PW'(total_q);
	end

	// range bounds from the held beat
	logic [XW-1:0] end_b, lo_r, hi_r;
	always_comb begin
		end_b = XW'(addr_q) + XW'(len_q);
		if (op_q == OP_RESERVE) begin
			lo_r = XW'(addr_q) >> PS;
			hi_r = (end_b + XW'(PAGE_BYTES - 1)) >> PS;
		end else begin
			lo_r = (XW'(addr_q) + XW'(PAGE_BYTES - 1)) >> PS;
			hi_r = end_b >> PS;
		end
	end

	// word-level masks for the current span
	logic [WA-1:0]     word;
	logic [5:0]        off;
	logic [PW-1:0]     span_left;
	logic [WordW-1:0]  lo_mask, span_mask, free_bits;
	logic [6:0]        nbits;
	logic [5:0]        fs;
	logic [PW-1:0]     found_pg;
	always_comb begin
		word      = WA'(lo_q >> 6);
		off       = lo_q[5:0];
		span_left = hi_q - lo_q;
		nbits     = (span_left < PW'(7'd64 - 7'(off))) ? 7'(span_left) : (7'd64 - 7'(off));
		lo_mask   = {WordW{1'b1}} << off;
		span_mask = (nbits == 7'd64) ? {WordW{1'b1}}
		          : (((WordW'(1) << nbits) - WordW'(1)) << off);
		free_bits = ~rdata & lo_mask;
		fs        = first_set(free_bits);
		found_pg  = {lo_q[PW-1:6], 6'd0} | PW'(fs);
	end

	logic [PW-1:0] next_lo;
	assign next_lo = PW'({lo_q[PW-1:6], 6'd0}) + PW'(64);

	logic [PW-1:0] free_pg;
	assign free_pg = PW'(addr_q >> PS);

	always_comb begin
		raddr = word;
		waddr = word;
		we    = 1'b0;
		wdata = rdata;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = WA'(clr_q);
			wdata = '1;
		end else if (state_q == S_MOD) begin
			if (op_q == OP_ALLOC) begin
				if (free_bits != '0 && found_pg < hi_q) begin
					we    = 1'b1;
					wdata = rdata | (WordW'(1) << fs);
				end
			end else begin
				we    = 1'b1;
				wdata = (op_q == OP_RESERVE) ? (rdata | span_mask) : (rdata & ~span_mask);
			end
		end else if (state_q == S_FREE) begin
			if (rdata[off]) begin
				we    = 1'b1;
				wdata = rdata & ~(WordW'(1) << off);
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {5'd0, res_st_q, res_addr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			total_q <= CntW'(65536);
			hint_q  <= CntW'(1);
			clr_q   <= '0;
			op_q    <= OP_ALLOC;
			wrap_q  <= 1'b0;
			res_st_q <= ST_OK;
		end else begin
			if (cfg_we) total_q <= cfg_wdata;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WAW'(1);
					if (clr_q == WAW'(Words - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						addr_q  <= s_tdata[47:0];
						len_q   <= s_tdata[95:48];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					res_addr_q <= '0;
					res_st_q   <= ST_OK;
					wrap_q     <= 1'b0;
					case (op_q)
						OP_ALLOC: begin
							lo_q       <= PW'(hint_q);
							hi_q       <= count;
							wrap_end_q <= (PW'(hint_q) < count) ? PW'(hint_q) : count;
							state_q    <= S_RD;
						end
						OP_FREE: begin
							lo_q <= free_pg;
							if (addr_q == '0) begin
								res_st_q <= ST_FREE_ZERO;
								state_q  <= S_OUT;
							end else if (addr_q[PS-1:0] != '0) begin
								res_st_q <= ST_UNALIGNED;
								state_q  <= S_OUT;
							end else if ((addr_q >> PS) >= AddrW'(count)) begin
								res_st_q <= ST_BEYOND;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_RD;
							end
						end
						default: begin
							lo_q <= PW'(lo_r);
							if (lo_r < hi_r) begin
								if (hi_r > XW'(count)) begin
									res_st_q <= ST_CLIPPED;
									hi_q     <= count;
									state_q  <= (lo_r < XW'(count)) ? S_RD : S_OUT;
								end else begin
									hi_q    <= PW'(hi_r);
									state_q <= S_RD;
								end
							end else begin
								state_q <= S_OUT;
							end
						end
					endcase
				end
				S_RD: begin
					if (op_q == OP_ALLOC && lo_q >= hi_q) begin
						if (!wrap_q) begin
							wrap_q  <= 1'b1;
							lo_q    <= PW'(1);
							hi_q    <= wrap_end_q;
						end else begin
							res_st_q <= ST_NO_MEM;
							state_q  <= S_OUT;
						end
					end else begin
						state_q <= (op_q == OP_FREE) ? S_FREE : S_MOD;
					end
				end
				S_MOD: begin
					if (op_q == OP_ALLOC) begin
						if (free_bits != '0 && found_pg < hi_q) begin
							hint_q     <= CntW'(found_pg + PW'(1));
							res_addr_q <= AddrW'(found_pg) << PS;
							state_q    <= S_OUT;
						end else begin
							lo_q    <= next_lo;
							state_q <= S_RD;
						end
					end else begin
						lo_q    <= lo_q + PW'(nbits);
						state_q <= (lo_q + PW'(nbits) < hi_q) ? S_RD : S_OUT;
					end
				end
				S_FREE: begin
					if (rdata[off]) begin
						if (CntW'(lo_q) < hint_q) hint_q <= CntW'(lo_q);
					end else begin
						res_st_q <= ST_DBL_FREE;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the allocated page is never page zero
	`BPA_ASSERT(a_no_page0, clk, arst_n, (m_tvalid && res_st_q == ST_OK && op_q == OP_ALLOC) |-> (res_addr_q != '0), "allocate returned page zero")
	// no beat is taken while the sweep runs
	`BPA_ASSERT(a_clear_block, clk, arst_n, (state_q == S_CLEAR) |-> !s_tready, "beat accepted during clear")
	// failed operations report a zero address
	`BPA_ASSERT(a_fail_zero, clk, arst_n, (m_tvalid && res_st_q != ST_OK) |-> (res_addr_q == '0), "nonzero address on failure")
	// a result waits for the sink
	`BPA_ASSERT(a_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped")
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bitmap page allocator: a local next-fit model
// of the page map predicts every result beat, which is compared field by
// field as it leaves the block under random idling on both streams
// ----------------------------------------------------------------------------
module tb_top;
	import bpa_pkg::*;

	localparam int unsigned NPAGES = MaxPagesDef;
	localparam int unsigned NWORDS = NPAGES / 64;
	localparam logic [63:0] PBYTES = 64'(PageBytesDef);

	typedef struct packed {
		logic [AddrW-1:0] page_addr;
		status_t          status;
	} alloc_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CntW-1:0]   cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [95:0]       s_tdata;   // address[47:0], length[95:48]
	logic [1:0]        s_tuser;   // operation[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [55:0]       m_tdata;   // page_address[47:0], status[50:48]

	// local copy of the allocator state
	logic [63:0]       mdl_map [NWORDS];
	logic [CntW-1:0]   mdl_hint;
	logic [CntW-1:0]   mdl_total;

	alloc_result_t     pending_results [$];
	logic [AddrW-1:0]  handed_out [$];   // pages given out by allocate, for plausible frees
	int                errors;
	int                hold_req;          // receiver hold-off request, in cycles

	bitmap_page_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// managed page count, clamped to the map size
	function automatic int unsigned managed_pages();
		return (mdl_total > NPAGES) ? NPAGES : int'(mdl_total);
	endfunction

	// first free page in [lo, hi), hi when none; whole used words are skipped
	function automatic int unsigned first_free(int unsigned lo, int unsigned hi);
		int unsigned i;
		i = lo;
		while (i < hi) begin
			if (&mdl_map[i >> 6])
				i = (i | 63) + 1;
			else if (!mdl_map[i >> 6][i & 63])
				return i;
			else
				i++;
		end
		return hi;
	endfunction

	function automatic void mark_pages(int unsigned lo, int unsigned hi, logic used);
		for (int unsigned p = lo; p < hi; p++)
			mdl_map[p >> 6][p & 63] = used;
	endfunction

	// next-fit allocator behavior for one accepted beat
	function automatic alloc_result_t allocator_step(op_t op, logic [47:0] addr,
			logic [47:0] len);
		alloc_result_t r;
		int unsigned   cnt, wrap_end, p;
		logic [63:0]   page, lo, hi, span_end;
		r.page_addr = '0;
		r.status    = ST_OK;
		cnt = managed_pages();
		case (op)
			OP_ALLOC: begin
				wrap_end = (mdl_hint < cnt) ? int'(mdl_hint) : cnt;
				p = first_free(mdl_hint, cnt);
				if (p >= cnt) begin
					p = first_free(1, wrap_end);
					if (p >= wrap_end) p = NPAGES + 1;
				end
				if (p <= NPAGES && p < cnt) begin
					mdl_map[p >> 6][p & 63] = 1'b1;
					mdl_hint    = CntW'(p + 1);
					r.page_addr = 48'(64'(p) * PBYTES);
					handed_out.push_back(r.page_addr);
				end else begin
					r.status = ST_NO_MEM;
				end
			end
			OP_FREE: begin
				page = 64'(addr) / PBYTES;
				if (addr == '0)
					r.status = ST_FREE_ZERO;
				else if ((64'(addr) % PBYTES) != 0)
					r.status = ST_UNALIGNED;
				else if (page >= 64'(cnt))
					r.status = ST_BEYOND;
				else if (!mdl_map[page >> 6][page & 63])
					r.status = ST_DBL_FREE;
				else begin
					mdl_map[page >> 6][page & 63] = 1'b0;
					if (page < 64'(mdl_hint)) mdl_hint = CntW'(page);
				end
			end
			default: begin
				span_end = 64'(addr) + 64'(len);
				if (op == OP_RESERVE) begin
					lo = 64'(addr) / PBYTES;
					hi = (span_end + PBYTES - 1) / PBYTES;
				end else begin
					lo = (64'(addr) + PBYTES - 1) / PBYTES;
					hi = span_end / PBYTES;
				end
				if (lo < hi) begin
					if (hi > 64'(cnt)) begin
						r.status = ST_CLIPPED;
						hi = 64'(cnt);
					end
					if (lo < hi) mark_pages(int'(lo), int'(hi), op == OP_RESERVE);
				end
			end
		endcase
		return r;
	endfunction

	// sender idle gap: mostly none, sometimes short, rarely long
	function automatic int send_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// one input beat; called and returning at a falling edge
	task automatic send_beat(op_t op, logic [47:0] addr, logic [47:0] len, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {len, addr};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(allocator_step(op, addr, len));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// register write while idle
	task automatic set_page_count(logic [CntW-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mdl_total = v;
	endtask

	// extremes of the fields and every status code
	task automatic test_directed();
		set_page_count(17'd65536);
		send_beat(OP_ALLOC, '0, '0, 0);                          // map full after reset
		send_beat(OP_FREE, '0, '0, 0);                           // page zero
		send_beat(OP_FREE, 48'h1001, '0, 1);                     // unaligned
		send_beat(OP_FREE, '1, '1, 0);                           // all ones, unaligned
		send_beat(OP_FREE, 48'(64'(NPAGES) * PBYTES), '0, 0);   // beyond memory
		send_beat(OP_RELEASE, '0, 48'(10 * PageBytesDef), 0);    // frees page 0 too
		send_beat(OP_FREE, 48'(PageBytesDef), '0, 2);            // double free
		send_beat(OP_ALLOC, '0, '0, 0);
		send_beat(OP_ALLOC, '0, '0, 0);
		send_beat(OP_FREE, 48'(PageBytesDef), '0, 0);            // lowers the hint
		send_beat(OP_RESERVE, 48'(3 * PageBytesDef + 5), 48'd1, 0);
		send_beat(OP_RESERVE, 48'h5000, '0, 0);                  // empty range
		send_beat(OP_RELEASE, 48'd1, 48'(PageBytesDef), 0);      // empty after rounding in
		send_beat(OP_RELEASE, 48'(65530 * PageBytesDef), 48'(20 * PageBytesDef), 0);
		send_beat(OP_RESERVE, '1, '1, 0);                        // clipped, nothing below count
		send_beat(OP_ALLOC, '0, '0, 0);
		send_beat(OP_ALLOC, '0, '0, 3);
		send_beat(OP_RESERVE, '0, 48'(64 * PageBytesDef), 0);
		send_beat(OP_ALLOC, '0, '0, 0);                          // scans forward past the reserved words
	endtask

	// tiny counts: wrap of the next-fit search, zero and oversized counts
	task automatic test_count_limits();
		set_page_count(17'd64);
		send_beat(OP_RELEASE, '0, 48'(64 * PageBytesDef), 0);
		repeat (66) send_beat(OP_ALLOC, '0, '0, send_gap());     // runs out of memory
		send_beat(OP_FREE, 48'(5 * PageBytesDef), '0, 0);
		send_beat(OP_ALLOC, '0, '0, 0);
		send_beat(OP_FREE, 48'(64 * PageBytesDef), '0, 0);
		set_page_count(17'd1);
		send_beat(OP_RELEASE, '0, 48'(4 * PageBytesDef), 0);
		send_beat(OP_ALLOC, '0, '0, 0);                          // page zero is never given
		set_page_count(17'd0);
		send_beat(OP_ALLOC, '0, '0, 0);
		send_beat(OP_FREE, 48'(PageBytesDef), '0, 0);
		send_beat(OP_RESERVE, '0, 48'd1, 0);
		set_page_count(17'h1FFFF);
		send_beat(OP_FREE, 48'(65535 * PageBytesDef), '0, 0);
		send_beat(OP_RELEASE, 48'(65000 * PageBytesDef), 48'(600 * PageBytesDef), 0);
		send_beat(OP_ALLOC, '0, '0, 0);
	endtask

	// mostly well-formed traffic on a count, some raw noise
	task automatic test_random_traffic(logic [CntW-1:0] count, int n);
		int unsigned cnt, r, pg, span;
		logic [47:0] a, l;
		op_t         op;
		set_page_count(count);
		cnt = (count > NPAGES) ? NPAGES : count;
		for (int k = 0; k < n; k++) begin
			r    = $urandom_range(0, 99);
			pg   = $urandom_range(0, cnt + 2);
			span = $urandom_range(0, 70);
			a = 48'(64'(pg) * PBYTES);
			l = 48'(64'(span) * PBYTES);
			if (r < 35) begin
				op = OP_ALLOC;
				a = 48'($urandom); l = 48'($urandom);
			end else if (r < 58) begin
				op = OP_FREE;
				if (handed_out.size() != 0 && $urandom_range(0, 2) != 0) begin
					pg = $urandom_range(0, handed_out.size() - 1);
					a  = handed_out[pg];
					handed_out.delete(pg);
				end
			end else if (r < 76) begin
				op = OP_RELEASE;
				if ($urandom_range(0, 3) == 0) begin
					a = a + 48'($urandom_range(0, 4095));
					l = l + 48'($urandom_range(0, 4095));
				end
			end else if (r < 88) begin
				op = OP_RESERVE;
				if ($urandom_range(0, 1) == 0) a = a + 48'($urandom_range(0, 4095));
				l = 48'($urandom_range(0, 3 * PageBytesDef));
			end else begin
				op = op_t'($urandom_range(0, 3));
				a  = {16'($urandom), 32'($urandom)};
				l  = {16'($urandom), 32'($urandom)};
				if ($urandom_range(0, 1) == 0) a = a >> $urandom_range(0, 47);
				if ($urandom_range(0, 1) == 0) l = l >> $urandom_range(0, 47);
			end
			send_beat(op, a, l, send_gap());
		end
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_stall();
		set_page_count(17'd512);
		send_beat(OP_RELEASE, '0, 48'(512 * PageBytesDef), 0);
		hold_req = 400;
		repeat (30) send_beat(OP_ALLOC, '0, '0, 0);
		repeat (10) send_beat(OP_FREE, handed_out.pop_front(), '0, 0);
	endtask

	// result checker: oldest expectation against each accepted beat
	initial begin
		alloc_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result beat: %h", m_tdata);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					if (m_tdata[47:0] !== exp_r.page_addr) begin
						$error("page_address: expected %h, actual %h",
							exp_r.page_addr, m_tdata[47:0]);
						errors++;
					end
					if (m_tdata[50:48] !== exp_r.status) begin
						$error("status: expected %0d, actual %0d",
							exp_r.status, m_tdata[50:48]);
						errors++;
					end
				end
			end
		end
	end

	// receiver: random stalls, quiet stretches, and requested long hold-offs
	initial begin
		int hold_left, run_left, r;
		hold_left = 0;
		run_left  = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (run_left > 0) begin
				m_tready <= 1'b1;
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2)
					hold_left = $urandom_range(15, 60);
				else if (r < 6)
					run_left = $urandom_range(30, 120);
				m_tready <= (r >= 25);
			end
		end
	end

	// watchdog
	initial begin
		#(64'd300_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_ALLOC;
		errors    = 0;
		hold_req  = 0;
		foreach (mdl_map[i]) mdl_map[i] = '1;
		mdl_hint  = 17'd1;
		mdl_total = 17'd65536;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_count_limits();
		test_output_stall();
		test_random_traffic(17'd4096, 400);
		test_random_traffic(17'd300, 400);
		test_random_traffic(17'd64 + 17'($urandom_range(0, 900)), 400);
		test_random_traffic(17'd65536, 150);
		test_random_traffic(17'd1, 40);
		test_random_traffic(17'h1FFFF, 60);
		test_random_traffic(17'd0, 40);

		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
